// ===== src/linear_array_deque_core_macros.svh =====
// ----------------------------------------------------------------------------
// linear_array_deque_core_macros.svh
// Assertion macros shared by the deque RTL. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ARRAY_DEQUE_CORE_MACROS_SVH
`define LINEAR_ARRAY_DEQUE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// checked on every edge outside reset
`define LAD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lad: assertion failed");

// checked on every edge, reset included
`define LAD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lad: assertion failed");

`else

`define LAD_ASSERT(lbl, clk, rst, prop)
`define LAD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== src/lad_pkg.sv =====
// ----------------------------------------------------------------------------
// lad_pkg
// Shared types and constants for the linear array deque.
// ----------------------------------------------------------------------------
package lad_pkg;

   // defaults for the top-level parameters
   localparam int LAD_DEPTH      = 8;
   localparam int LAD_DATA_WIDTH = 32;

   // fixed field widths on the ports
   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_INS_HEAD = 2'd0,
      OP_INS_TAIL = 2'd1,
      OP_REM_HEAD = 2'd2,
      OP_REM_TAIL = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE      = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // beat accepted: decide, update pointers, touch RAM
      logic capture;  // RAM read data is valid: take it as the result value
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fetch;    // the pending beat is a removal that reads the RAM
   } dp_stat_type;

endpackage

// ===== src/linear_array_deque_core.sv =====
// ----------------------------------------------------------------------------
// linear_array_deque_core
// Double-ended queue in a fixed, non-wrapping array of DEPTH slots.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser: op; tdata: data_in
//   rsp      out  rsp_tvalid/rsp_tready  tdata: data_out; tuser: status, is_empty
//
// One beat in flight at a time. An insert or a refused/underflow beat shows
// its result the cycle after accept; a successful removal first passes
// through a fetch state for the registered slot RAM read. The next beat is
// taken the cycle after the result beat leaves. Synchronous active-high reset
// empties the queue at once; slots keep garbage until written. Stalls on rsp
// hold the result and block req.
// ----------------------------------------------------------------------------
module linear_array_deque_core #(
   parameter int DEPTH      = lad_pkg::LAD_DEPTH,
   parameter int DATA_WIDTH = lad_pkg::LAD_DATA_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [lad_pkg::DATA_W-1:0] req_tdata,   // [31:0] data_in
   input  logic [lad_pkg::OP_W-1:0]   req_tuser,   // [1:0] op
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [lad_pkg::DATA_W-1:0] rsp_tdata,   // [31:0] data_out
   output logic [2:0]                 rsp_tuser    // [1:0] status, [2] is_empty
);
   import lad_pkg::*;

   ctl_cmd_type          cmd;
   dp_stat_type          stat;
   logic [STATUS_W-1:0]  status;
   logic                 is_empty;

   lad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lad_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .op       (req_tuser),
      .data_in  (req_tdata),
      .data_out (rsp_tdata),
      .status   (status),
      .is_empty (is_empty)
   );

   assign rsp_tuser = {is_empty, status};

endmodule

// ===== src/lad_ram.sv =====
// ----------------------------------------------------------------------------
// lad_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lad_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/lad_ctrl.sv =====
// ----------------------------------------------------------------------------
// lad_ctrl
// Handshake controller: accept one beat, optionally wait for the RAM read,
// then hold the result until the sink takes it.
// ----------------------------------------------------------------------------
module lad_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  lad_pkg::dp_stat_type stat,
   output lad_pkg::ctl_cmd_type cmd
);
   import lad_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = stat.fetch ? S_FETCH : S_RESP;
            end
         end
         S_FETCH: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd.load    = 1'b0;
      cmd.capture = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_FETCH: begin
            cmd.capture = 1'b1;
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ===== src/lad_dpath.sv =====
// ----------------------------------------------------------------------------
// lad_dpath
// Deque datapath: head/tail pointers, empty flag, slot RAM and result regs.
// ----------------------------------------------------------------------------
`include "linear_array_deque_core_macros.svh"

module lad_dpath #(
   parameter int DEPTH      = lad_pkg::LAD_DEPTH,
   parameter int DATA_WIDTH = lad_pkg::LAD_DATA_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lad_pkg::ctl_cmd_type         cmd,
   output lad_pkg::dp_stat_type         stat,
   input  logic [lad_pkg::OP_W-1:0]     op,
   input  logic [lad_pkg::DATA_W-1:0]   data_in,
   output logic [lad_pkg::DATA_W-1:0]   data_out,
   output logic [lad_pkg::STATUS_W-1:0] status,
   output logic                         is_empty
);
   import lad_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W-1:0] ONE  = PTR_W'(1);

   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic                  empty_ff, empty_in;
   logic [DATA_W-1:0]     data_out_ff, data_out_in;
   status_type            status_ff, status_in;
   logic                  is_empty_ff;

   logic                  ram_we, ram_re;
   logic [PTR_W-1:0]      ram_waddr, ram_raddr;
   logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
   op_type                op_cur;
   logic                  is_insert;

   assign op_cur    = op_type'(op);
   assign is_insert = (op_cur == OP_INS_HEAD) || (op_cur == OP_INS_TAIL);
   // value kept in the low DATA_WIDTH bits, zero filled above 32
   assign ram_wdata = DATA_WIDTH'({32'd0, data_in});

   // removal of a live element needs a RAM read cycle
   assign stat.fetch = !is_insert && !empty_ff;

   // operation decode: pointer moves, RAM access, status
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      status_in = STAT_DONE;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_re    = 1'b0;
      ram_raddr = head_ff;
      if (is_insert) begin
         if (empty_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b0;
            ram_we   = cmd.load;
         end else if (op_cur == OP_INS_HEAD) begin
            if (head_ff == '0) begin
               status_in = STAT_OVERFLOW;
            end else begin
               head_in   = head_ff - ONE;
               ram_we    = cmd.load;
               ram_waddr = head_ff - ONE;
            end
         end else begin
            if (tail_ff == LAST) begin
               status_in = STAT_OVERFLOW;
            end else begin
               tail_in   = tail_ff + ONE;
               ram_we    = cmd.load;
               ram_waddr = tail_ff + ONE;
            end
         end
      end else begin
         if (empty_ff) begin
            status_in = STAT_UNDERFLOW;
         end else begin
            ram_re    = cmd.load;
            ram_raddr = (op_cur == OP_REM_HEAD) ? head_ff : tail_ff;
            if (head_ff == tail_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b1;
            end else if (op_cur == OP_REM_HEAD) begin
               head_in = head_ff + ONE;
            end else begin
               tail_in = tail_ff - ONE;
            end
         end
      end
   end

   // result value: zero on accept, RAM data on capture
   always_comb begin
      data_out_in = data_out_ff;
      if (cmd.load) begin
         data_out_in = '0;
      end else if (cmd.capture) begin
         data_out_in = DATA_W'(ram_rdata);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (cmd.load) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      data_out_ff <= data_out_in;
      if (cmd.load) begin
         status_ff   <= status_in;
         is_empty_ff <= empty_in;
      end
   end

   lad_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign data_out = data_out_ff;
   assign status   = status_ff;
   assign is_empty = is_empty_ff;

   // checks
   `LAD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (empty_ff && head_ff == '0 && tail_ff == '0))
   `LAD_ASSERT(a_empty_ptrs, clock, reset, empty_ff |-> (head_ff == '0 && tail_ff == '0))
   `LAD_ASSERT(a_head_le_tail, clock, reset, !empty_ff |-> (head_ff <= tail_ff))
   `LAD_ASSERT(a_ram_one_port, clock, reset, !(ram_we && ram_re))

endmodule
